[src/fr_pkg.sv]
// Shared types, widths and constants for the Fresnel reflectance pipeline.
// No dependencies; fresnel_reflectance and fr_div_cell refer to this package.
package fr_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 15;
   localparam int WORK_FRAC           = 16;
   localparam int INDEX_FRAC          = 10;
   localparam int FIELD_W             = 16;

   // Internal Q.16 values that can reach 1.0 need one extra bit.
   localparam int COS_W  = WORK_FRAC + 1;
   localparam int R_W    = 31;
   localparam int QQ_W   = 31;
   localparam int H_RAD_W = 60;
   localparam int P_RAD_W = 48;
   localparam int NUM_W  = 56;
   localparam int QUOT_W = WORK_FRAC + 1;
   localparam int DIV_LANES = 2;

   localparam logic [FIELD_W-1:0] INDEX_REAL_RESET = 16'd1024;
   localparam logic [FIELD_W-1:0] INDEX_IMAG_RESET = 16'd0;

   typedef enum logic [0:0] {
      CSR_INDEX_REAL = 1'b0,
      CSR_INDEX_IMAG = 1'b1
   } fr_csr_type;

   typedef struct packed {
      logic [COS_W-1:0] c;
      logic [COS_W-1:0] c2;
      logic [COS_W-1:0] s2;
      logic             grazing;
   } fr_angle_type;

   typedef struct packed {
      logic signed [R_W-1:0] r;
      fr_angle_type          ang;
   } fr_side_h_type;

   typedef struct packed {
      logic [QQ_W-1:0] qq;
      fr_angle_type    ang;
   } fr_side_p_type;

endpackage

[src/fresnel_reflectance.sv]
// Unpolarised Fresnel reflectance of an absorbing surface with index n+ik, fully pipelined.
// Depends on fr_pkg, fr_sqrt_cell and fr_div_cell.
//
// A cosine is taken on every clock cycle at which start is high; busy is always low. The
// result appears on rsp_reflectance and rsp_absorptivity, marked by rsp_strobe for a single
// cycle, in order, one result per beat. The receiver cannot stall the pipeline, so results
// must be captured when the strobe is seen. The pipeline is made of the two square-root
// cell rows (30 and 24 cells, one root bit each), the divider row (17 cells, one quotient
// bit for both ratios each) and 13 arithmetic stages. Write index_real and index_imag only
// while no beat is in flight.
module fresnel_reflectance #(
   parameter int ANGLE_FRAC_BITS = fr_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [fr_pkg::FIELD_W-1:0]  req_cos_incidence,
   output logic                        rsp_strobe,
   output logic [fr_pkg::FIELD_W-1:0]  rsp_reflectance,
   output logic [fr_pkg::FIELD_W-1:0]  rsp_absorptivity,
   input  logic                        csr_wr_en,
   input  logic [0:0]                  csr_index,
   input  logic [fr_pkg::FIELD_W-1:0]  csr_wr_data
);

   localparam int A      = ANGLE_FRAC_BITS;
   localparam int WF     = fr_pkg::WORK_FRAC;
   localparam int CW     = fr_pkg::COS_W;
   localparam int FW     = fr_pkg::FIELD_W;
   localparam int H_RAD  = fr_pkg::H_RAD_W;
   localparam int H_ROOT = H_RAD / 2;
   localparam int P_RAD  = fr_pkg::P_RAD_W;
   localparam int P_ROOT = P_RAD / 2;
   localparam int NW     = fr_pkg::NUM_W;
   localparam int QW     = fr_pkg::QUOT_W;
   localparam int LANES  = fr_pkg::DIV_LANES;
   localparam int LATENCY = 13 + H_ROOT + P_ROOT + QW;

   localparam int SAT_W = (A + 1 > CW) ? A + 1 : CW;
   localparam logic [A:0] ONE_A = {1'b1, {A{1'b0}}};

   // Cosine from Q.A to Q.16.
   localparam int LSH_C = (A < WF) ? WF - A : 0;
   localparam int RSH_C = (A > WF) ? A - WF : 0;
   localparam int C_W   = CW + 10;
   localparam logic [C_W-1:0] HALF_C = (C_W'(1) << RSH_C) >> 1;

   // Squares of the cosine from Q.2A to Q.16.
   localparam int SH2 = 2 * A - WF;
   localparam int W2  = (2 * A + 2 > 35) ? 2 * A + 2 : 35;
   localparam logic [W2-1:0] HALF_2 = (W2'(1) << SH2) >> 1;

   // Index products from Q.20 to Q.16.
   localparam int IX_SH = 2 * fr_pkg::INDEX_FRAC - WF;
   localparam logic [33:0] IX_HALF = (34'd1 << IX_SH) >> 1;

   // Average from Q.17 to Q.A.
   localparam int LSH_R = (A > WF + 1) ? A - WF - 1 : 0;
   localparam int RSH_R = (A < WF + 1) ? WF + 1 - A : 0;
   localparam int RW    = 30;
   localparam logic [RW-1:0] HALF_R = (RW'(1) << RSH_R) >> 1;

   localparam logic [QW-1:0] Q_ONE = {1'b1, {WF{1'b0}}};

   // ---------------------------------------------------------------- registers
   logic [FW-1:0] index_real_ff, index_imag_ff;

   logic          va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic          vg_ff, vh_ff, vi_ff, vj_ff, vk_ff, vl_ff;
   logic          rsp_strobe_ff;

   // Stage A: saturated cosine.
   logic [CW-1:0]  cin_ff, cin_in;
   // Stage B: Q.16 angle terms and index products.
   fr_pkg::fr_angle_type ang_b_ff, ang_b_in;
   logic [28:0]    n2_ff, n2_in, k2_ff, k2_in, m_b_ff, m_b_in;
   // Stage C: r and |r|.
   fr_pkg::fr_angle_type ang_c_ff;
   logic signed [fr_pkg::R_W-1:0] r_c_ff, r_c_in;
   logic [28:0]    ur_ff, ur_in, m_c_ff;
   // Stage D: squares.
   fr_pkg::fr_angle_type ang_d_ff;
   logic signed [fr_pkg::R_W-1:0] r_d_ff;
   logic [57:0]    urr_ff, urr_in, mm_ff, mm_in;
   // Stage E: radicand of h.
   fr_pkg::fr_side_h_type side_e_ff;
   logic [H_RAD-1:0] rad_h_ff, rad_h_in;
   // Stage F: p^2 and q^2.
   fr_pkg::fr_side_p_type side_f_ff, side_f_in;
   logic [fr_pkg::QQ_W-1:0] pp_ff, pp_in;
   // Stage G.
   logic [CW+7:0]  dpc_ff, dpc_in, spc_ff, spc_in;
   logic [P_ROOT+CW-1:0] pcprod_ff, pcprod_in;
   logic [47:0]    qc_g_ff, qc_g_in;
   logic [fr_pkg::QQ_W-1:0] qq_g_ff;
   logic [CW-1:0]  s2_g_ff;
   logic           graz_g_ff;
   // Stage H.
   logic [49:0]    sqn_ff, sqn_in, sqd_ff, sqd_in;
   logic [25:0]    pc_ff, pc_in;
   logic [47:0]    qc_h_ff;
   logic [fr_pkg::QQ_W-1:0] qq_h_ff;
   logic [CW-1:0]  s2_h_ff;
   logic           graz_h_ff;
   // Stage I.
   logic [NW-1:0]  numn_i_ff, numn_i_in, denn_i_ff, denn_i_in;
   logic [25:0]    dps_ff, dps_in;
   logic [26:0]    sps_ff, sps_in;
   logic [47:0]    qc_i_ff;
   logic           graz_i_ff;
   // Stage J.
   logic [NW-1:0]  numn_j_ff, denn_j_ff;
   logic [51:0]    sqnp_ff, sqnp_in;
   logic [53:0]    sqdp_ff, sqdp_in;
   logic [47:0]    qc_j_ff;
   logic           graz_j_ff;
   // Stage K: numerators and denominators of both ratios.
   logic [NW-1:0]  numn_k_ff, denn_k_ff, nump_k_ff, nump_k_in, denp_k_ff, denp_k_in;
   logic           graz_k_ff;
   // Stage L.
   logic [2*QW-1:0] rp_prod_ff, rp_prod_in;
   logic [QW-1:0]  rn_l_ff, rn_l_in;
   logic           graz_l_ff;
   // Output.
   logic [FW-1:0]  refl_ff, refl_in, absb_ff, absb_in;

   assign busy = 1'b0;

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         index_real_ff <= fr_pkg::INDEX_REAL_RESET;
         index_imag_ff <= fr_pkg::INDEX_IMAG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fr_pkg::CSR_INDEX_REAL: index_real_ff <= csr_wr_data;
            fr_pkg::CSR_INDEX_IMAG: index_imag_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stages A to E
   always_comb begin
      logic [SAT_W-1:0] cin_ext, sat;
      cin_ext = SAT_W'(req_cos_incidence);
      sat     = (cin_ext > SAT_W'(ONE_A)) ? SAT_W'(ONE_A) : cin_ext;
      cin_in  = sat[CW-1:0];
   end

   always_comb begin
      logic [C_W-1:0]  c_full;
      logic [33:0]     cin_sq;
      logic [W2-1:0]   sq_w, c2_full, s2_full;
      logic [31:0]     nn, kk, nk;
      logic [33:0]     n2_full, k2_full, m_full;
      c_full  = ((C_W'(cin_ff) << LSH_C) + HALF_C) >> RSH_C;
      cin_sq  = 34'(cin_ff) * 34'(cin_ff);
      sq_w    = W2'(cin_sq);
      c2_full = (sq_w + HALF_2) >> SH2;
      s2_full = ((W2'(1) << (2 * A)) - sq_w + HALF_2) >> SH2;
      nn      = index_real_ff * index_real_ff;
      kk      = index_imag_ff * index_imag_ff;
      nk      = index_real_ff * index_imag_ff;
      n2_full = (34'(nn) + IX_HALF) >> IX_SH;
      k2_full = (34'(kk) + IX_HALF) >> IX_SH;
      m_full  = ({1'b0, nk, 1'b0} + IX_HALF) >> IX_SH;
      ang_b_in.c       = c_full[CW-1:0];
      ang_b_in.c2      = c2_full[CW-1:0];
      ang_b_in.s2      = s2_full[CW-1:0];
      ang_b_in.grazing = c_full[CW-1:0] == '0;
      n2_in  = n2_full[28:0];
      k2_in  = k2_full[28:0];
      m_b_in = m_full[28:0];
   end

   always_comb begin
      logic signed [fr_pkg::R_W-1:0] r_neg;
      r_c_in = $signed(31'(n2_ff) - 31'(k2_ff) - 31'(ang_b_ff.s2));
      r_neg  = -r_c_in;
      ur_in  = r_c_in[fr_pkg::R_W-1] ? r_neg[28:0] : r_c_in[28:0];
   end

   assign urr_in   = 58'(ur_ff) * 58'(ur_ff);
   assign mm_in    = 58'(m_c_ff) * 58'(m_c_ff);
   assign rad_h_in = H_RAD'(urr_ff) + H_RAD'(mm_ff);

   always_ff @(posedge clock) begin
      cin_ff    <= cin_in;
      ang_b_ff  <= ang_b_in;
      n2_ff     <= n2_in;
      k2_ff     <= k2_in;
      m_b_ff    <= m_b_in;
      ang_c_ff  <= ang_b_ff;
      r_c_ff    <= r_c_in;
      ur_ff     <= ur_in;
      m_c_ff    <= m_b_ff;
      ang_d_ff  <= ang_c_ff;
      r_d_ff    <= r_c_ff;
      urr_ff    <= urr_in;
      mm_ff     <= mm_in;
      side_e_ff.r   <= r_d_ff;
      side_e_ff.ang <= ang_d_ff;
      rad_h_ff  <= rad_h_in;
   end

   // ---------------------------------------------------------------- root h = sqrt(r^2 + m^2)
   localparam int SH_W = $bits(fr_pkg::fr_side_h_type);
   logic                h_valid [H_ROOT+1];
   logic [H_RAD-1:0]    h_rad   [H_ROOT+1];
   logic [H_ROOT+1:0]   h_rem   [H_ROOT+1];
   logic [H_ROOT-1:0]   h_root  [H_ROOT+1];
   logic [SH_W-1:0]     h_side  [H_ROOT+1];

   assign h_valid[0] = ve_ff;
   assign h_rad[0]   = rad_h_ff;
   assign h_rem[0]   = '0;
   assign h_root[0]  = '0;
   assign h_side[0]  = side_e_ff;

   for (genvar i = 0; i < H_ROOT; i++) begin : g_h_cell
      fr_sqrt_cell #(.RAD_W(H_RAD), .SIDE_W(SH_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_valid[i]),
         .in_rad    (h_rad[i]),
         .in_rem    (h_rem[i]),
         .in_root   (h_root[i]),
         .in_side   (h_side[i]),
         .out_valid (h_valid[i+1]),
         .out_rad   (h_rad[i+1]),
         .out_rem   (h_rem[i+1]),
         .out_root  (h_root[i+1]),
         .out_side  (h_side[i+1])
      );
   end

   // ---------------------------------------------------------------- stage F
   always_comb begin
      fr_pkg::fr_side_h_type sh;
      logic signed [32:0] h_s, r_s, hpr, hmr;
      sh  = h_side[H_ROOT];
      h_s = {3'b000, h_root[H_ROOT]};
      r_s = {{2{sh.r[fr_pkg::R_W-1]}}, sh.r};
      hpr = h_s + r_s;
      hmr = h_s - r_s;
      pp_in        = hpr[31:1];
      side_f_in.qq = hmr[31:1];
      side_f_in.ang = sh.ang;
   end

   always_ff @(posedge clock) begin
      pp_ff     <= pp_in;
      side_f_ff <= side_f_in;
   end

   // ---------------------------------------------------------------- root p = sqrt(p^2)
   localparam int SP_W = $bits(fr_pkg::fr_side_p_type);
   logic                p_valid [P_ROOT+1];
   logic [P_RAD-1:0]    p_rad   [P_ROOT+1];
   logic [P_ROOT+1:0]   p_rem   [P_ROOT+1];
   logic [P_ROOT-1:0]   p_root  [P_ROOT+1];
   logic [SP_W-1:0]     p_side  [P_ROOT+1];

   assign p_valid[0] = vf_ff;
   assign p_rad[0]   = {1'b0, pp_ff, {WF{1'b0}}};
   assign p_rem[0]   = '0;
   assign p_root[0]  = '0;
   assign p_side[0]  = side_f_ff;

   for (genvar i = 0; i < P_ROOT; i++) begin : g_p_cell
      fr_sqrt_cell #(.RAD_W(P_RAD), .SIDE_W(SP_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (p_valid[i]),
         .in_rad    (p_rad[i]),
         .in_rem    (p_rem[i]),
         .in_root   (p_root[i]),
         .in_side   (p_side[i]),
         .out_valid (p_valid[i+1]),
         .out_rad   (p_rad[i+1]),
         .out_rem   (p_rem[i+1]),
         .out_root  (p_root[i+1]),
         .out_side  (p_side[i+1])
      );
   end

   // ---------------------------------------------------------------- stages G to K
   fr_pkg::fr_side_p_type side_p;
   assign side_p = p_side[P_ROOT];

   always_comb begin
      logic [CW+7:0] p_w, c_w;
      p_w       = (CW + 8)'(p_root[P_ROOT]);
      c_w       = (CW + 8)'(side_p.ang.c);
      dpc_in    = (p_w >= c_w) ? p_w - c_w : c_w - p_w;
      spc_in    = p_w + c_w;
      pcprod_in = (P_ROOT + CW)'(p_root[P_ROOT]) * (P_ROOT + CW)'(side_p.ang.c);
      qc_g_in   = 48'(side_p.qq) * 48'(side_p.ang.c2);
   end

   always_comb begin
      logic [P_ROOT+CW:0] pc_full;
      sqn_in  = 50'(dpc_ff) * 50'(dpc_ff);
      sqd_in  = 50'(spc_ff) * 50'(spc_ff);
      pc_full = ((P_ROOT + CW + 1)'(pcprod_ff) + (P_ROOT + CW + 1)'(1 << (WF - 1))) >> WF;
      pc_in   = pc_full[25:0];
   end

   always_comb begin
      logic [25:0] s2_w;
      numn_i_in = NW'(sqn_ff) + (NW'(qq_h_ff) << WF);
      denn_i_in = NW'(sqd_ff) + (NW'(qq_h_ff) << WF);
      s2_w      = 26'(s2_h_ff);
      dps_in    = (pc_ff >= s2_w) ? pc_ff - s2_w : s2_w - pc_ff;
      sps_in    = 27'(pc_ff) + 27'(s2_w);
   end

   assign sqnp_in   = 52'(dps_ff) * 52'(dps_ff);
   assign sqdp_in   = 54'(sps_ff) * 54'(sps_ff);
   assign nump_k_in = NW'(sqnp_ff) + NW'(qc_j_ff);
   assign denp_k_in = NW'(sqdp_ff) + NW'(qc_j_ff);

   always_ff @(posedge clock) begin
      dpc_ff    <= dpc_in;
      spc_ff    <= spc_in;
      pcprod_ff <= pcprod_in;
      qc_g_ff   <= qc_g_in;
      qq_g_ff   <= side_p.qq;
      s2_g_ff   <= side_p.ang.s2;
      graz_g_ff <= side_p.ang.grazing;

      sqn_ff    <= sqn_in;
      sqd_ff    <= sqd_in;
      pc_ff     <= pc_in;
      qc_h_ff   <= qc_g_ff;
      qq_h_ff   <= qq_g_ff;
      s2_h_ff   <= s2_g_ff;
      graz_h_ff <= graz_g_ff;

      numn_i_ff <= numn_i_in;
      denn_i_ff <= denn_i_in;
      dps_ff    <= dps_in;
      sps_ff    <= sps_in;
      qc_i_ff   <= qc_h_ff;
      graz_i_ff <= graz_h_ff;

      numn_j_ff <= numn_i_ff;
      denn_j_ff <= denn_i_ff;
      sqnp_ff   <= sqnp_in;
      sqdp_ff   <= sqdp_in;
      qc_j_ff   <= qc_i_ff;
      graz_j_ff <= graz_i_ff;

      numn_k_ff <= numn_j_ff;
      denn_k_ff <= denn_j_ff;
      nump_k_ff <= nump_k_in;
      denp_k_ff <= denp_k_in;
      graz_k_ff <= graz_j_ff;
   end

   // ---------------------------------------------------------------- divider row
   // Lane 0 forms RN, lane 1 the tan-weighted ratio. Both quotients are at most 1.0,
   // so the dividend (numerator shifted up 16) needs only 17 quotient steps.
   logic              d_valid [QW+1];
   logic              d_graz  [QW+1];
   logic [NW:0]       d_rem   [QW+1][LANES];
   logic [NW-1:0]     d_den   [QW+1][LANES];
   logic [QW-1:0]     d_low   [QW+1][LANES];
   logic [QW-1:0]     d_quot  [QW+1][LANES];

   assign d_valid[0]   = vk_ff;
   assign d_graz[0]    = graz_k_ff;
   assign d_rem[0][0]  = (NW + 1)'(numn_k_ff >> 1);
   assign d_rem[0][1]  = (NW + 1)'(nump_k_ff >> 1);
   assign d_den[0][0]  = denn_k_ff;
   assign d_den[0][1]  = denp_k_ff;
   assign d_low[0][0]  = {numn_k_ff[0], {WF{1'b0}}};
   assign d_low[0][1]  = {nump_k_ff[0], {WF{1'b0}}};
   assign d_quot[0][0] = '0;
   assign d_quot[0][1] = '0;

   for (genvar i = 0; i < QW; i++) begin : g_div_cell
      fr_div_cell #(.DEN_W(NW), .Q_W(QW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (d_valid[i]),
         .in_grazing  (d_graz[i]),
         .in_rem      (d_rem[i]),
         .in_den      (d_den[i]),
         .in_low      (d_low[i]),
         .in_quot     (d_quot[i]),
         .out_valid   (d_valid[i+1]),
         .out_grazing (d_graz[i+1]),
         .out_rem     (d_rem[i+1]),
         .out_den     (d_den[i+1]),
         .out_low     (d_low[i+1]),
         .out_quot    (d_quot[i+1])
      );
   end

   // ---------------------------------------------------------------- valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0; vd_ff <= 1'b0;
         ve_ff <= 1'b0; vf_ff <= 1'b0; vg_ff <= 1'b0; vh_ff <= 1'b0;
         vi_ff <= 1'b0; vj_ff <= 1'b0; vk_ff <= 1'b0; vl_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         va_ff <= start && !busy;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= h_valid[H_ROOT];
         vg_ff <= p_valid[P_ROOT];
         vh_ff <= vg_ff;
         vi_ff <= vh_ff;
         vj_ff <= vi_ff;
         vk_ff <= vj_ff;
         vl_ff <= d_valid[QW];
         rsp_strobe_ff <= vl_ff;
      end
   end

   // ---------------------------------------------------------------- stages L and output
   // Where a denominator is zero, the ratio is taken as one.
   always_comb begin
      logic [QW-1:0] rat;
      rn_l_in = (d_den[QW][0] == '0) ? Q_ONE : d_quot[QW][0];
      rat     = (d_den[QW][1] == '0) ? Q_ONE : d_quot[QW][1];
      rp_prod_in = (2 * QW)'(rn_l_in) * (2 * QW)'(rat);
   end

   always_comb begin
      logic [2*QW:0] rp_full;
      logic [RW-1:0] sum, refl_full;
      logic [A:0]    refl_a, absb_a;
      rp_full   = ((2 * QW + 1)'(rp_prod_ff) + (2 * QW + 1)'(1 << (WF - 1))) >> WF;
      sum       = RW'(rn_l_ff) + RW'(rp_full);
      refl_full = ((sum << LSH_R) + HALF_R) >> RSH_R;
      if (graz_l_ff || refl_full > RW'(ONE_A)) begin
         refl_a = ONE_A;
      end else begin
         refl_a = refl_full[A:0];
      end
      absb_a  = ONE_A - refl_a;
      refl_in = ((A + 1)'(refl_a) > (A + 1)'({FW{1'b1}})) ? {FW{1'b1}} : FW'(refl_a);
      absb_in = ((A + 1)'(absb_a) > (A + 1)'({FW{1'b1}})) ? {FW{1'b1}} : FW'(absb_a);
   end

   always_ff @(posedge clock) begin
      rp_prod_ff <= rp_prod_in;
      rn_l_ff    <= rn_l_in;
      graz_l_ff  <= d_graz[QW];
      refl_ff    <= refl_in;
      absb_ff    <= absb_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_reflectance  = refl_ff;
   assign rsp_absorptivity = absb_ff;

   // ---------------------------------------------------------------- assertions
   localparam logic [FW:0] ONE_SAT = (A < FW) ? (FW + 1)'(ONE_A) : (FW + 1)'({FW{1'b1}});

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("result beat missing at the pipeline latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result beat without a matching request beat");

   a_sum_one : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (A < FW) |->
         (FW + 1)'(rsp_reflectance) + (FW + 1)'(rsp_absorptivity) == ONE_SAT)
      else $error("reflectance and absorptivity do not add up to one");

   a_grazing : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cos_incidence == '0 |->
         ##LATENCY (FW + 1)'(rsp_reflectance) == ONE_SAT)
      else $error("grazing incidence did not give full reflectance");

endmodule

[src/fr_sqrt_cell.sv]
// One digit cell of the pipelined integer square root: settles one root bit per beat.
// Uses no package items; side data rides along with the operand unchanged.
module fr_sqrt_cell #(
   parameter int RAD_W  = 60,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [RAD_W-1:0]       in_rad,
   input  logic [RAD_W/2+1:0]     in_rem,
   input  logic [RAD_W/2-1:0]     in_root,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [RAD_W-1:0]       out_rad,
   output logic [RAD_W/2+1:0]     out_rem,
   output logic [RAD_W/2-1:0]     out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int ROOT_W = RAD_W / 2;

   logic                valid_ff;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [ROOT_W+1:0]   rem_sh, trial;
   logic                take;

   // The partial remainder never exceeds twice the partial root, so the
   // top bits dropped by the shifts are always zero.
   always_comb begin
      rem_sh  = {in_rem[ROOT_W-1:0], in_rad[RAD_W-1 -: 2]};
      trial   = {1'b0, in_root[ROOT_W-2:0], 2'b01};
      take    = rem_sh >= trial;
      rem_in  = take ? rem_sh - trial : rem_sh;
      root_in = {in_root[ROOT_W-2:0], take};
      rad_in  = {in_rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

[src/fr_div_cell.sv]
// One step cell of the pipelined restoring divider: one quotient bit per lane per beat.
// Depends on fr_pkg for the lane count.
module fr_div_cell #(
   parameter int DEN_W = 56,
   parameter int Q_W   = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_grazing,
   input  logic [DEN_W:0]    in_rem  [fr_pkg::DIV_LANES],
   input  logic [DEN_W-1:0]  in_den  [fr_pkg::DIV_LANES],
   input  logic [Q_W-1:0]    in_low  [fr_pkg::DIV_LANES],
   input  logic [Q_W-1:0]    in_quot [fr_pkg::DIV_LANES],
   output logic              out_valid,
   output logic              out_grazing,
   output logic [DEN_W:0]    out_rem  [fr_pkg::DIV_LANES],
   output logic [DEN_W-1:0]  out_den  [fr_pkg::DIV_LANES],
   output logic [Q_W-1:0]    out_low  [fr_pkg::DIV_LANES],
   output logic [Q_W-1:0]    out_quot [fr_pkg::DIV_LANES]
);

   logic              valid_ff;
   logic              grazing_ff;
   logic [DEN_W:0]    rem_ff  [fr_pkg::DIV_LANES];
   logic [DEN_W:0]    rem_in  [fr_pkg::DIV_LANES];
   logic [DEN_W-1:0]  den_ff  [fr_pkg::DIV_LANES];
   logic [Q_W-1:0]    low_ff  [fr_pkg::DIV_LANES];
   logic [Q_W-1:0]    low_in  [fr_pkg::DIV_LANES];
   logic [Q_W-1:0]    quot_ff [fr_pkg::DIV_LANES];
   logic [Q_W-1:0]    quot_in [fr_pkg::DIV_LANES];

   // The incoming remainder is below the divisor, so it fits DEN_W bits
   // before the next numerator bit is shifted in.
   always_comb begin
      logic [DEN_W:0] rem_sh;
      logic           take;
      for (int l = 0; l < fr_pkg::DIV_LANES; l++) begin
         rem_sh     = {in_rem[l][DEN_W-1:0], in_low[l][Q_W-1]};
         take       = rem_sh >= {1'b0, in_den[l]};
         rem_in[l]  = take ? rem_sh - {1'b0, in_den[l]} : rem_sh;
         quot_in[l] = {in_quot[l][Q_W-2:0], take};
         low_in[l]  = {in_low[l][Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      grazing_ff <= in_grazing;
      rem_ff     <= rem_in;
      den_ff     <= in_den;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
   end

   assign out_valid   = valid_ff;
   assign out_grazing = grazing_ff;
   assign out_rem     = rem_ff;
   assign out_den     = den_ff;
   assign out_low     = low_ff;
   assign out_quot    = quot_ff;

endmodule
